@@ design/rmm_pkg.sv @@
package rmm_pkg;

    localparam int MAX_WINDOW_DEF = 63;

    localparam int SAMPLE_W = 8;
    localparam int CNT_W    = 6;

    // seen-sample counter saturates here, above every right reach
    localparam logic [CNT_W-1:0] COUNT_SAT = 6'd63;
    localparam logic [CNT_W-1:0] WIN_RESET = 6'd3;

    // configuration register indexes
    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_MODE        = 1'b1;

    // mode codes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                line_end;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last_of_line;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

@@ design/rmm_cell.sv @@
// One cell of the window row: holds one stored sample (shifts on a new
// item) and one partial reduction that flows toward cell 0 every cycle.
module rmm_cell #(
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic                         i_mode,
    input  logic [rmm_pkg::CNT_W-1:0]    i_depth,
    input  logic [rmm_pkg::SAMPLE_W-1:0] i_data,
    input  logic [rmm_pkg::SAMPLE_W-1:0] i_acc,
    output logic [rmm_pkg::SAMPLE_W-1:0] o_data,
    output logic [rmm_pkg::SAMPLE_W-1:0] o_acc
);

    logic [rmm_pkg::SAMPLE_W-1:0] r_data;
    logic [rmm_pkg::SAMPLE_W-1:0] r_acc;
    logic [rmm_pkg::SAMPLE_W-1:0] n_acc;
    logic                         w_take_nbr;

    always_comb begin
        // pick the neighbor's value when it wins the compare
        if (i_mode == rmm_pkg::MODE_DILATE) begin
            w_take_nbr = (i_acc > r_data);
        end else begin
            w_take_nbr = (i_acc < r_data);
        end
        // the deepest cell of the window starts the reduction on its own sample
        if (int'(i_depth) == IDX) begin
            n_acc = r_data;
        end else if (w_take_nbr) begin
            n_acc = i_acc;
        end else begin
            n_acc = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
        r_acc <= n_acc;
    end

    assign o_data = r_data;
    assign o_acc  = r_acc;

endmodule

@@ design/running_minmax_filter_1d.sv @@
// Channel  Handshake                   Payload                         Direction
// in       i_in_valid / o_in_ready     i_in_data  (sample, line_end)   into block
// out      o_out_valid / i_out_ready   o_out_data (value, last_of_line) out of block
// cfg      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data          into block
//
// A sample goes through a transfer, a reduction that ripples down the cell row
// from cell D to cell 0, D = min(samples already seen in the line, k-1), and a
// hand-over of the result to the output register.
// The last sample of a line is followed by r = k-1-k/2 internal border passes
// (the last sample replicated).
// Reset (synchronous, active low) clears control and configuration; there is
// no clearing pass, since a reduction never reaches past the line start.
// A stalled output holds the block in its result cycle; config is always ready.
module running_minmax_filter_1d #(
    parameter int MAX_WINDOW = rmm_pkg::MAX_WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input samples
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  rmm_pkg::t_in_item            i_in_data,
    // filtered samples
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output rmm_pkg::t_out_item           o_out_data,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [rmm_pkg::CNT_W-1:0]    i_cfg_data
);

    localparam int CW = rmm_pkg::CNT_W;
    localparam int SW = rmm_pkg::SAMPLE_W;

    // configuration
    logic          r_win;
    logic [CW-1:0] r_win_size;
    logic          r_mode;

    // sequencer
    rmm_pkg::t_state r_state;
    rmm_pkg::t_state n_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_depth;
    logic            r_emit;
    logic            r_final;
    logic [CW-1:0]   r_pads;
    logic [CW-1:0]   r_seen;

    // output register
    logic               r_out_valid;
    rmm_pkg::t_out_item r_out;

    // window geometry
    logic [CW-1:0] w_k;
    logic [CW-1:0] w_half;
    logic [CW-1:0] w_reach;
    logic [CW-1:0] w_item_depth;
    logic          w_item_emit;
    logic          w_item_final;

    logic          w_in_xfer;
    logic          w_done_go;
    logic          w_pad_start;
    logic          w_start;
    logic          w_out_load;
    logic [SW-1:0] w_shift_val;

    // cell row
    logic [SW-1:0] w_data [MAX_WINDOW];
    logic [SW-1:0] w_acc  [MAX_WINDOW];

    assign o_cfg_ready = 1'b1;

    always_comb begin
        // zero acts as a copy window; the row length limits k
        w_k = (r_win_size == '0) ? CW'(1) : r_win_size;
        if (int'(w_k) > MAX_WINDOW) begin
            w_k = CW'(MAX_WINDOW);
        end
        w_half  = w_k >> 1;
        w_reach = w_k - CW'(1) - w_half;
        // clamp to the line start: older positions repeat the first sample
        w_item_depth = (r_seen < (w_k - CW'(1))) ? r_seen : (w_k - CW'(1));
        w_item_emit  = (r_seen >= w_reach);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rmm_pkg::S_RUN;
                end
            end
            rmm_pkg::S_RUN: begin
                if (r_count == '0) begin
                    n_state = rmm_pkg::S_DONE;
                end
            end
            rmm_pkg::S_DONE: begin
                if (w_done_go) begin
                    n_state = (r_pads != '0) ? rmm_pkg::S_RUN : rmm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmm_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        o_in_ready  = (r_state == rmm_pkg::S_IDLE);
        w_in_xfer   = i_in_valid && o_in_ready;
        w_done_go   = (r_state == rmm_pkg::S_DONE) &&
                      (!r_emit || !r_out_valid || i_out_ready);
        w_pad_start = w_done_go && (r_pads != '0);
        w_start     = w_in_xfer || w_pad_start;
        w_out_load  = w_done_go && r_emit;
        // border pass re-enters the newest stored sample
        w_shift_val = w_in_xfer ? i_in_data.sample : w_data[0];
        if (w_in_xfer) begin
            w_item_final = i_in_data.line_end && (w_reach == '0);
        end else begin
            w_item_final = (r_pads == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmm_pkg::S_IDLE;
            r_count     <= '0;
            r_depth     <= '0;
            r_emit      <= 1'b0;
            r_final     <= 1'b0;
            r_pads      <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
            r_win_size  <= rmm_pkg::WIN_RESET;
            r_mode      <= rmm_pkg::MODE_ERODE;
        end else begin
            r_state <= n_state;

            if (r_state == rmm_pkg::S_RUN && r_count != '0) begin
                r_count <= r_count - CW'(1);
            end

            if (w_start) begin
                r_depth <= w_item_depth;
                r_count <= w_item_depth;
                r_emit  <= w_item_emit;
                r_final <= w_item_final;
                if (w_item_final) begin
                    r_seen <= '0;
                end else if (r_seen != rmm_pkg::COUNT_SAT) begin
                    r_seen <= r_seen + CW'(1);
                end
                if (w_in_xfer) begin
                    r_pads <= i_in_data.line_end ? w_reach : '0;
                end else begin
                    r_pads <= r_pads - CW'(1);
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rmm_pkg::CFG_WINDOW_SIZE: r_win_size <= i_cfg_data;
                    rmm_pkg::CFG_MODE:        r_mode     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // one-bit shadow of the mode write, kept for the mode-steady check
    always_ff @(posedge i_clk) begin
        r_win <= r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.value        <= w_acc[0];
            r_out.last_of_line <= r_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- cell row: index 0 holds the newest sample ----------------
    genvar c;
    generate
        for (c = 0; c < MAX_WINDOW; c++) begin : g_cell
            logic [SW-1:0] w_prev;
            logic [SW-1:0] w_nbr;
            if (c == 0) begin : g_head
                assign w_prev = w_shift_val;
            end else begin : g_body
                assign w_prev = w_data[c-1];
            end
            if (c == MAX_WINDOW - 1) begin : g_tail
                assign w_nbr = '0;
            end else begin : g_link
                assign w_nbr = w_acc[c+1];
            end
            rmm_cell #(
                .IDX (c)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_start),
                .i_mode  (r_mode),
                .i_depth (r_depth),
                .i_data  (w_prev),
                .i_acc   (w_nbr),
                .o_data  (w_data[c]),
                .o_acc   (w_acc[c])
            );
        end
    endgenerate

    // ---------------- assertions ----------------
    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rmm_pkg::S_RUN |-> r_count <= r_depth)
        else $error("reduction counter beyond window depth");

    a_depth_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != rmm_pkg::S_IDLE |-> int'(r_depth) < MAX_WINDOW)
        else $error("window depth beyond cell row");

    a_no_pads_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rmm_pkg::S_IDLE |-> r_pads == '0)
        else $error("border passes left pending while idle");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start && w_item_final |=> r_seen == '0)
        else $error("line position not cleared after final item");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load && r_final |-> r_pads == '0 && r_emit)
        else $error("line-end result issued with passes pending");

    a_mode_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rmm_pkg::S_RUN && $past(r_state) == rmm_pkg::S_RUN |-> r_win == r_mode)
        else $error("mode changed during a reduction");

endmodule
